// ===== design/tdp_pkg.sv =====
// Package for the trial-division prime tester: widths, item kinds and the
// queue word shared by the front, queue and back modules. No dependencies.
`default_nettype none
package tdp_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int DIV_BITS    = (VALUE_BITS + 1) / 2 + 2;
    localparam int SQ_BITS     = VALUE_BITS + 1;
    localparam int REM_BITS    = DIV_BITS + 1;
    localparam int CNT_BITS    = $clog2(VALUE_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    typedef enum logic [1:0] {
        KIND_NOT_PRIME,
        KIND_PRIME,
        KIND_TRIAL
    } tdp_kind_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        tdp_kind_t             kind;
    } tdp_entry_t;

    typedef struct packed {
        logic       valid;
        tdp_entry_t entry;
    } tdp_word_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_BOUND,
        B_DIVIDE
    } tdp_state_t;

endpackage
`default_nettype wire

// ===== design/trial_division_prime_test.sv =====
// Top level of the trial-division prime tester: front classifier, word queue
// and divider back end. Depends on tdp_pkg, tdp_front, tdp_queue, tdp_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------
//   input    | start & !busy      | value [VALUE_BITS-1:0]
//   result   | done (one cycle)   | is_prime
//
// A word of 0, 1, 2 or an even value is answered from the front register,
// the queue and the back end's done register, without division. An odd word
// of 3 or more runs each odd divisor tried through a bound check and the
// bit-serial remainder unit in the back end, with one last bound check when it
// proves prime. The front and queue hold up to three words while the back end
// works; busy rises when all are full.
// Reset clears all control state; the result side never stalls.
`default_nettype none
module trial_division_prime_test (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [tdp_pkg::VALUE_BITS-1:0] value,
    output logic                                done,
    output logic                                is_prime
);
    import tdp_pkg::*;

    tdp_word_t push;
    tdp_word_t head;
    logic      q_ready;
    logic      pop;

    tdp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .value   (value),
        .busy    (busy),
        .q_ready (q_ready),
        .push    (push)
    );

    tdp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .q_ready (q_ready),
        .head    (head),
        .pop     (pop)
    );

    tdp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .done     (done),
        .is_prime (is_prime)
    );

endmodule
`default_nettype wire

// ===== design/tdp_front.sv =====
// Front stage: accepts a word, classifies it (trivial answer or trial division)
// and hands it to the queue. Depends on tdp_pkg.
`default_nettype none
module tdp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tdp_pkg::VALUE_BITS-1:0] value,
    output logic                               busy,
    input  wire logic                          q_ready,
    output tdp_pkg::tdp_word_t                 push
);
    import tdp_pkg::*;

    logic       front_valid_reg;
    logic       front_valid_next;
    tdp_entry_t entry_reg;
    tdp_kind_t  kind;
    logic       accept;
    logic       pushed;

    always_comb
    begin
        if (value < VALUE_BITS'(2))
            kind = KIND_NOT_PRIME;
        else if (value == VALUE_BITS'(2))
            kind = KIND_PRIME;
        else if (!value[0])
            kind = KIND_NOT_PRIME;
        else
            kind = KIND_TRIAL;
    end

    assign pushed           = front_valid_reg && q_ready;
    assign busy             = front_valid_reg && !q_ready;
    assign accept           = start && !busy;
    assign front_valid_next = accept || (front_valid_reg && !pushed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg.value <= value;
            entry_reg.kind  <= kind;
        end
    end

    assign push = {front_valid_reg, entry_reg};

endmodule
`default_nettype wire

// ===== design/tdp_queue.sv =====
// Two-entry queue between the front and back stages.
// Depends on tdp_pkg.
`default_nettype none
module tdp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tdp_pkg::tdp_word_t push,
    output logic                    q_ready,
    output tdp_pkg::tdp_word_t      head,
    input  wire logic               pop
);
    import tdp_pkg::*;

    tdp_entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg;
    logic [QCNT_BITS-1:0]  count_next;
    logic                  do_push;
    logic                  do_pop;

    assign q_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign do_push = push.valid && q_ready;
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.entry;
    end

    assign head = {(count_reg != '0), mem[rd_ptr_reg]};

endmodule
`default_nettype wire

// ===== design/tdp_back.sv =====
// Back stage: answers trivial words at once, runs odd trial divisors with a
// bit-serial remainder unit for the rest. Depends on tdp_pkg.
`default_nettype none
module tdp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tdp_pkg::tdp_word_t head,
    output logic                    pop,
    output logic                    done,
    output logic                    is_prime
);
    import tdp_pkg::*;

    tdp_state_t             state_reg;
    tdp_state_t             state_next;
    logic [VALUE_BITS-1:0]  v_reg;
    logic [VALUE_BITS-1:0]  v_next;
    logic [VALUE_BITS-1:0]  shr_reg;
    logic [VALUE_BITS-1:0]  shr_next;
    logic [DIV_BITS-1:0]    d_reg;
    logic [DIV_BITS-1:0]    d_next;
    logic [SQ_BITS-1:0]     sq_reg;
    logic [SQ_BITS-1:0]     sq_next;
    logic [REM_BITS-1:0]    rem_reg;
    logic [REM_BITS-1:0]    rem_next;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [CNT_BITS-1:0]    cnt_next;
    logic                   done_reg;
    logic                   done_next;
    logic                   prime_reg;
    logic                   prime_next;

    logic [REM_BITS-1:0]    rem_shift;
    logic [REM_BITS-1:0]    rem_step;
    logic                   bound_over;
    logic                   last_bit;

    assign rem_shift  = {rem_reg[REM_BITS-2:0], shr_reg[VALUE_BITS-1]};
    assign rem_step   = (rem_shift >= REM_BITS'(d_reg)) ? rem_shift - REM_BITS'(d_reg)
                                                        : rem_shift;
    assign bound_over = sq_reg > SQ_BITS'(v_reg);
    assign last_bit   = (cnt_reg == CNT_BITS'(VALUE_BITS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (head.valid && head.entry.kind == KIND_TRIAL)
                    state_next = B_BOUND;
            end
            B_BOUND:
            begin
                state_next = bound_over ? B_IDLE : B_DIVIDE;
            end
            B_DIVIDE:
            begin
                if (last_bit)
                    state_next = (rem_step == '0) ? B_IDLE : B_BOUND;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        done_next  = 1'b0;
        prime_next = prime_reg;
        v_next     = v_reg;
        shr_next   = shr_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    pop    = 1'b1;
                    v_next = head.entry.value;
                    d_next = DIV_BITS'(3);
                    sq_next = SQ_BITS'(9);
                    if (head.entry.kind != KIND_TRIAL)
                    begin
                        done_next  = 1'b1;
                        prime_next = (head.entry.kind == KIND_PRIME);
                    end
                end
            end
            B_BOUND:
            begin
                shr_next = v_reg;
                rem_next = '0;
                cnt_next = '0;
                if (bound_over)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                end
            end
            B_DIVIDE:
            begin
                shr_next = {shr_reg[VALUE_BITS-2:0], 1'b0};
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (last_bit)
                begin
                    if (rem_step == '0)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                    else
                    begin
                        d_next  = d_reg + DIV_BITS'(2);
                        // (d+2)^2 = d^2 + 4d + 4
                        sq_next = sq_reg + SQ_BITS'({d_reg, 2'b00}) + SQ_BITS'(4);
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg <= prime_next;
        v_reg     <= v_next;
        shr_reg   <= shr_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
    end

    assign done     = done_reg;
    assign is_prime = prime_reg;

endmodule
`default_nettype wire

// ===== verif/prime_verdict_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for trial_division_prime_test. It predicts the prime verdict of each
// accepted word and checks it against the done/is_prime result stream.
// Depends on tdp_pkg.
module prime_verdict_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [tdp_pkg::VALUE_BITS-1:0] value,
    input  logic                           done,
    input  logic                           is_prime,
    output int                             fail_count,
    output int                             pending
);
    import tdp_pkg::*;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  verdict;
    } verdict_t;

    verdict_t expected_verdicts[$];
    int       error_total = 0;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // exact bound d*d <= n, kept as d <= n/d
    function automatic logic trial_divide_prime(input logic [VALUE_BITS-1:0] v);
        longint unsigned n;
        longint unsigned d;
        n = v;
        if (n < 2)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if ((n & 1) == 0)
            return 1'b0;
        for (d = 3; d <= n / d; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        error_total++;
        $display("ERROR %0t: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        verdict_t head;
        if (rst_n === 1'b1)
        begin
            // pop before push: a result never belongs to the word taken at the same edge
            if (done === 1'b1)
            begin
                if (expected_verdicts.size() == 0)
                    flag_mismatch($sformatf("is_prime=%b with no word outstanding", is_prime));
                else
                begin
                    head = expected_verdicts.pop_front();
                    if (is_prime !== head.verdict)
                        flag_mismatch($sformatf("value %0d: is_prime=%b, expected %b",
                                                head.value, is_prime, head.verdict));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                expected_verdicts.push_back('{value, trial_divide_prime(value)});
        end
        fail_count <= error_total;
        pending    <= expected_verdicts.size();
    end

endmodule

// ===== verif/trial_division_prime_test_test.sv =====
`timescale 1ns / 1ps
// Testbench top for trial_division_prime_test: resets the block, feeds corner and
// random words with random gaps, and gives the verdict. Depends on tdp_pkg and
// prime_verdict_checker.
module trial_division_prime_test_test;
    import tdp_pkg::*;

    localparam int IDLE_LIMIT   = 200_000;
    localparam int RANDOM_WORDS = 80;
    localparam int DRAIN_CYCLES = 20;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [VALUE_BITS-1:0] value = '0;
    logic                  busy;
    logic                  done;
    logic                  is_prime;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles = 0;

    always #5 clk = ~clk;

    trial_division_prime_test u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .done     (done),
        .is_prime (is_prime)
    );

    prime_verdict_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .done       (done),
        .is_prime   (is_prime),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && busy === 1'b0) || done === 1'b1)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("trial_division_prime_test verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // mostly cheap words: small values, full-width evens, full-width multiples of small odds
    function automatic logic [VALUE_BITS-1:0] random_word();
        int          kind;
        int unsigned factor;
        kind = $urandom_range(0, 99);
        if (kind < 40)
            return $urandom_range(0, 2047);
        if (kind < 60)
            return $urandom_range(0, (1 << 18) - 1);
        if (kind < 80)
            return $urandom & ~32'd1;
        factor = 2 * $urandom_range(1, 15) + 1;
        return factor * $urandom_range(0, 32'hFFFF_FFFF / factor);
    endfunction

    task automatic send_word(input logic [VALUE_BITS-1:0] v, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            value <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    function automatic int pick_gap(input int idx);
        int r;
        if ((idx / 16) % 3 == 2)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        logic [VALUE_BITS-1:0] corner_words[];
        corner_words = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd15,
            32'd25, 32'd49, 32'd221, 32'd63001, 32'd65521, 32'd65537,
            32'd16777213, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
            32'h8000_0001, 32'hAAAA_AAAA, 32'h5555_5555
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (corner_words[i])
            send_word(corner_words[i], pick_gap(i));
        for (int i = 0; i < RANDOM_WORDS; i++)
            send_word(random_word(), pick_gap(i));
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("trial_division_prime_test verification clean");
        else
            $display("trial_division_prime_test verification failed");
        $finish;
    end

endmodule
